### rtl/nearest_point_heading_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heading controller
// Shorthand for clocked properties; the using scope supplies clock and reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_HEADING_CONTROLLER_ASSERT_SVH
`define NEAREST_POINT_HEADING_CONTROLLER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NPHC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NPHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/nphc_pkg.sv
// ----------------------------------------------------------------------------
// nphc_pkg
// Shared types, codes and constants of the nearest point heading controller.
// ----------------------------------------------------------------------------
package nphc_pkg;

   // item kinds
   localparam int OPCODE_W = 2;
   localparam logic [OPCODE_W-1:0] OP_POINT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_JOINT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] REG_MOUNT_OFFSET  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LOOP_GAIN     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_DEADBAND      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_RATE      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

   localparam int MOUNT_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int DEADBAND_W = 15;
   localparam int MAX_RATE_W = 15;
   localparam int TICK_W    = 8;

   localparam logic signed [MOUNT_W-1:0]  MOUNT_RESET    = 16'sd6434;
   localparam logic [GAIN_W-1:0]          GAIN_RESET     = 16'd4096;
   localparam logic [DEADBAND_W-1:0]      DEADBAND_RESET = 15'd410;
   localparam logic [MAX_RATE_W-1:0]      MAX_RATE_RESET = 15'd2048;
   localparam logic [TICK_W-1:0]          TIMEOUT_RESET  = 8'd10;
   localparam logic [TICK_W-1:0]          TICK_MAX       = 8'hFF;

   // angle formats
   localparam int BEARING_W   = 16;
   localparam int RATE_OUT_W  = 16;
   localparam int PI_Q12      = 12868;
   localparam int TWO_PI_Q12  = 25736;
   localparam int WRAPPED_W   = 15;
   localparam int PROD_W      = WRAPPED_W + GAIN_W + 1;
   localparam int RATE_SHIFT  = 12;
   localparam int RATE_W      = PROD_W - RATE_SHIFT;

   // CORDIC: vectors scaled to a fixed 56-bit span, angle in Q.24
   localparam int CORDIC_SPAN = 56;
   localparam int CORDIC_W    = CORDIC_SPAN + 3;
   localparam int Z_W         = 28;
   localparam int HALF_PI_Q24 = 26353589;
   localparam int Z_ROUND     = 2048;
   localparam int Z_SHIFT     = 12;

   localparam int STEP_W = 5;

   // result kinds
   localparam logic [1:0] OUT_ZERO    = 2'd0;
   localparam logic [1:0] OUT_TIMEOUT = 2'd1;
   localparam logic [1:0] OUT_RATE    = 2'd2;

   typedef struct packed {
      logic              capture;
      logic              pt_update;
      logic              cord_step;
      logic              bear_write;
      logic              err_load;
      logic              wrap_step;
      logic              mul_load;
      logic              out_load;
      logic [1:0]        out_kind;
      logic [STEP_W-1:0] step;
   } nphc_cmd_type;

   typedef struct packed {
      logic last_point;
      logic publish_ok;
      logic timeout_hit;
   } nphc_status_type;

   // error word must hold bearing - waist - mount without overflow
   function automatic int err_width(input int angle_w);
      return ((angle_w > MOUNT_W) ? angle_w : MOUNT_W) + 2;
   endfunction

   function automatic logic signed [Z_W-1:0] atan_q24(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:  v = Z_W'(13176795);
         5'd1:  v = Z_W'(7778716);
         5'd2:  v = Z_W'(4110060);
         5'd3:  v = Z_W'(2086331);
         5'd4:  v = Z_W'(1047214);
         5'd5:  v = Z_W'(524117);
         5'd6:  v = Z_W'(262123);
         5'd7:  v = Z_W'(131069);
         5'd8:  v = Z_W'(65536);
         5'd9:  v = Z_W'(32768);
         5'd10: v = Z_W'(16384);
         5'd11: v = Z_W'(8192);
         5'd12: v = Z_W'(4096);
         5'd13: v = Z_W'(2048);
         5'd14: v = Z_W'(1024);
         5'd15: v = Z_W'(512);
         5'd16: v = Z_W'(256);
         5'd17: v = Z_W'(128);
         5'd18: v = Z_W'(64);
         5'd19: v = Z_W'(32);
         5'd20: v = Z_W'(16);
         5'd21: v = Z_W'(8);
         5'd22: v = Z_W'(4);
         5'd23: v = Z_W'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/nphc_req_if.sv
// ----------------------------------------------------------------------------
// nphc_req_if
// Input item channel: point, joint angle or tick words.
// ----------------------------------------------------------------------------
interface nphc_req_if #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16
);
   import nphc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [OPCODE_W-1:0]           opcode;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          last_point;
   logic signed [ANGLE_WIDTH-1:0] joint_angle;

   modport source (output valid, opcode, point_x, point_y, last_point, joint_angle,
                   input ready);
   modport sink   (input valid, opcode, point_x, point_y, last_point, joint_angle,
                   output ready);
endinterface

### rtl/nphc_rsp_if.sv
// ----------------------------------------------------------------------------
// nphc_rsp_if
// Result channel: one command word per tick.
// ----------------------------------------------------------------------------
interface nphc_rsp_if;
   import nphc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         publish;
   logic signed [RATE_OUT_W-1:0] angular_rate;
   logic                         timed_out;

   modport source (output valid, publish, angular_rate, timed_out, input ready);
   modport sink   (input valid, publish, angular_rate, timed_out, output ready);
endinterface

### rtl/nphc_csr_if.sv
// ----------------------------------------------------------------------------
// nphc_csr_if
// Register write channel: index and data word.
// ----------------------------------------------------------------------------
interface nphc_csr_if;
   import nphc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/nearest_point_heading_controller.sv
// Point word: captured, then compared; last point of a frame: compare, CORDIC_STEPS
// micro-rotations, bearing write. Joint word: captured on accept. Tick word: error, then
// the result if timed out or not publishing, else WRAP_STEPS = max(ANGLE_WIDTH,16) - 12
// wrap steps, gain, rate. One word at a time; input waits through CORDIC and wrap steps.
// Reset is synchronous, active high: registers return to defaults, no frame or joint seen.
// ----------------------------------------------------------------------------
// nearest_point_heading_controller
// Turns toward the nearest point of each frame with a proportional rate command.
// ----------------------------------------------------------------------------
module nearest_point_heading_controller #(
   parameter int CORDIC_STEPS = 16,
   parameter int COORD_WIDTH  = 16,
   parameter int ANGLE_WIDTH  = 16
) (
   input logic        clock,
   input logic        reset,
   nphc_req_if.sink   req_ch,
   nphc_rsp_if.source rsp_ch,
   nphc_csr_if.sink   csr_ch
);
   import nphc_pkg::*;

   // the wrap search visits one power of two pi per cycle
   localparam int WRAP_STEPS = err_width(ANGLE_WIDTH) - 14;

   nphc_cmd_type    cmd;
   nphc_status_type status;
   logic            csr_write;

   // Registers take a write any cycle out of reset; the host must write only while idle, the block does not enforce it.
   assign csr_ch.ready = !reset;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // Sequencer: holds req ready only in its idle state, and holds the result
   // word in the output register until the sink takes it, so the next input
   // word may already be accepted while a result waits.
   nphc_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .WRAP_STEPS   (WRAP_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: squared distance search over the frame, iterative atan2 at its
   // last point; a tick: error, and for a rate wrap, deadband, gain, clamp.
   nphc_dpath #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_ch.opcode),
      .req_point_x      (req_ch.point_x),
      .req_point_y      (req_ch.point_y),
      .req_last_point   (req_ch.last_point),
      .req_joint_angle  (req_ch.joint_angle),
      .csr_write        (csr_write),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_publish      (rsp_ch.publish),
      .rsp_angular_rate (rsp_ch.angular_rate),
      .rsp_timed_out    (rsp_ch.timed_out)
   );

endmodule

### rtl/nphc_ctrl.sv
// ----------------------------------------------------------------------------
// nphc_ctrl
// Sequencer: dispatches items, runs CORDIC and wrap iterations, owns rsp valid.
// ----------------------------------------------------------------------------
module nphc_ctrl #(
   parameter int CORDIC_STEPS = 16,
   parameter int WRAP_STEPS   = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic [nphc_pkg::OPCODE_W-1:0]      req_opcode,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  nphc_pkg::nphc_status_type          status,
   output nphc_pkg::nphc_cmd_type             cmd
);
   import nphc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PT_UPD = 3'd1;
   localparam logic [2:0] S_CORD   = 3'd2;
   localparam logic [2:0] S_BEAR   = 3'd3;
   localparam logic [2:0] S_TICK   = 3'd4;
   localparam logic [2:0] S_WRAP   = 3'd5;
   localparam logic [2:0] S_MUL    = 3'd6;
   localparam logic [2:0] S_RATE   = 3'd7;

   localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(CORDIC_STEPS - 1);
   localparam logic [STEP_W-1:0] WRAP_TOP  = STEP_W'(WRAP_STEPS - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_opcode)
                  OP_POINT: state_in = S_PT_UPD;
                  OP_TICK:  state_in = S_TICK;
                  OP_JOINT: state_in = S_IDLE;
                  OP_NONE:  state_in = S_IDLE;
               endcase
            end
         end
         S_PT_UPD: begin
            cmd.pt_update = 1'b1;
            if (status.last_point) begin
               state_in = S_CORD;
               step_in  = '0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CORD: begin
            cmd.cord_step = 1'b1;
            if (step_ff == CORD_LAST) begin
               state_in = S_BEAR;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_BEAR: begin
            cmd.bear_write = 1'b1;
            state_in       = S_IDLE;
         end
         S_TICK: begin
            cmd.err_load = 1'b1;
            priority if (!status.publish_ok) begin
               if (out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = OUT_ZERO;
                  state_in     = S_IDLE;
               end
            end else if (status.timeout_hit) begin
               if (out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = OUT_TIMEOUT;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_WRAP;
               step_in  = WRAP_TOP;
            end
         end
         S_WRAP: begin
            cmd.wrap_step = 1'b1;
            if (step_ff == '0) begin
               state_in = S_MUL;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = S_RATE;
         end
         S_RATE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_RATE;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/nphc_dpath.sv
// ----------------------------------------------------------------------------
// nphc_dpath
// Datapath: registers, nearest point search, CORDIC, wrap, gain and clamp.
// ----------------------------------------------------------------------------
module nphc_dpath #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  nphc_pkg::nphc_cmd_type                  cmd,
   output nphc_pkg::nphc_status_type               status,
   input  logic [nphc_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic signed [COORD_WIDTH-1:0]           req_point_x,
   input  logic signed [COORD_WIDTH-1:0]           req_point_y,
   input  logic                                    req_last_point,
   input  logic signed [ANGLE_WIDTH-1:0]           req_joint_angle,
   input  logic                                    csr_write,
   input  logic [nphc_pkg::CSR_ADDR_W-1:0]         csr_index,
   input  logic [nphc_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic                                    rsp_publish,
   output logic signed [nphc_pkg::RATE_OUT_W-1:0]  rsp_angular_rate,
   output logic                                    rsp_timed_out
);
   import nphc_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int SQ_W   = 2 * CW - 1;
   localparam int DIST_W = 2 * CW;
   localparam int CSCALE = CORDIC_SPAN - CW;
   localparam int ERR_W  = err_width(ANGLE_WIDTH);
   localparam int WW     = ERR_W + 2;

   localparam logic signed [WW-1:0] PI_W     = WW'(PI_Q12);
   localparam logic signed [WW-1:0] TWO_PI_W = WW'(TWO_PI_Q12);

   // configuration
   logic signed [MOUNT_W-1:0] mount_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [DEADBAND_W-1:0]     deadband_ff;
   logic [MAX_RATE_W-1:0]     max_rate_ff;
   logic [TICK_W-1:0]         timeout_ff;

   // captured point and squares
   logic signed [CW-1:0]     px_ff, py_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic signed [DIST_W-1:0] sqx_full, sqy_full;
   logic                     last_ff;

   // frame search
   logic [DIST_W-1:0]    pt_dist;
   logic                 take;
   logic signed [CW-1:0] sel_x, sel_y;
   logic [DIST_W-1:0]    best_d_ff;
   logic signed [CW-1:0] best_x_ff, best_y_ff;
   logic                 frame_open_ff;

   // CORDIC
   logic signed [CORDIC_W-1:0] x0, y0;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [CORDIC_W-1:0] cx_ld, cy_ld;
   logic signed [Z_W-1:0]      cz_ff, cz_in, cz_ld;
   logic signed [CORDIC_W-1:0] xs, ys;
   logic signed [Z_W-1:0]      atan_v, z_round;

   // controller state of the model
   logic signed [BEARING_W-1:0]   bearing_ff;
   logic signed [ANGLE_WIDTH-1:0] waist_ff;
   logic                          have_frame_ff, have_joint_ff;
   logic [TICK_W-1:0]             ticks_ff;

   // error path
   logic signed [ERR_W-1:0]     err_raw;
   logic signed [WW-1:0]        w_ff, w_in, chunk, w_try;
   logic                        neg_ff;
   logic signed [WRAPPED_W-1:0] ew;
   logic [WRAPPED_W-1:0]        mag;
   logic signed [PROD_W-1:0]    prod_ff;
   logic                        dead_ff;
   logic signed [RATE_W-1:0]    r, max_s;
   logic signed [RATE_OUT_W-1:0] rate_sel;

   // result word
   logic                         pub_ff, to_ff;
   logic signed [RATE_OUT_W-1:0] rate_ff;

   assign status.last_point  = last_ff;
   assign status.publish_ok  = have_frame_ff && have_joint_ff;
   assign status.timeout_hit = (ticks_ff > timeout_ff) || (ticks_ff == TICK_MAX);

   assign rsp_publish      = pub_ff;
   assign rsp_angular_rate = rate_ff;
   assign rsp_timed_out    = to_ff;

   // squares, one register stage before the compare
   assign sqx_full = DIST_W'(req_point_x) * DIST_W'(req_point_x);
   assign sqy_full = DIST_W'(req_point_y) * DIST_W'(req_point_y);

   // nearest point: earliest wins on ties
   assign pt_dist = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   assign take    = !frame_open_ff || (pt_dist < best_d_ff);
   assign sel_x   = take ? px_ff : best_x_ff;
   assign sel_y   = take ? py_ff : best_y_ff;

   // scale into the CORDIC span and fold the left half plane
   assign x0 = CORDIC_W'(sel_x) <<< CSCALE;
   assign y0 = CORDIC_W'(sel_y) <<< CSCALE;

   always_comb begin
      cx_ld = x0;
      cy_ld = y0;
      cz_ld = '0;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            cx_ld = y0;
            cy_ld = -x0;
            cz_ld = Z_W'(HALF_PI_Q24);
         end else begin
            cx_ld = -y0;
            cy_ld = x0;
            cz_ld = -Z_W'(HALF_PI_Q24);
         end
      end
   end

   // one micro-rotation a cycle
   assign xs     = cx_ff >>> cmd.step;
   assign ys     = cy_ff >>> cmd.step;
   assign atan_v = atan_q24(cmd.step);

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      priority if (cmd.pt_update && last_ff) begin
         cx_in = cx_ld;
         cy_in = cy_ld;
         cz_in = cz_ld;
      end else if (cmd.cord_step) begin
         if (cy_ff > 0) begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + atan_v;
         end else if (cy_ff < 0) begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - atan_v;
         end
      end
   end

   assign z_round = cz_ff + Z_W'(Z_ROUND);

   // error wrap: binary search on the multiple of two pi, top chunk first
   assign err_raw = ERR_W'(bearing_ff) - ERR_W'(waist_ff) - ERR_W'(mount_ff);
   assign chunk   = TWO_PI_W << cmd.step;
   assign w_try   = neg_ff ? (w_ff + chunk) : (w_ff - chunk);

   always_comb begin
      w_in = w_ff;
      priority if (cmd.err_load) begin
         w_in = WW'(err_raw);
      end else if (cmd.wrap_step) begin
         if (neg_ff ? (w_try < PI_W) : (w_try > -PI_W)) begin
            w_in = w_try;
         end
      end
   end

   assign ew  = $signed(w_ff[WRAPPED_W-1:0]);
   assign mag = ew[WRAPPED_W-1] ? WRAPPED_W'(-ew) : ew;

   // floor shift, then clamp to the rate limit
   assign r     = prod_ff[PROD_W-1:RATE_SHIFT];
   assign max_s = $signed(RATE_W'(max_rate_ff));

   always_comb begin
      priority if (dead_ff) begin
         rate_sel = '0;
      end else if (r > max_s) begin
         rate_sel = RATE_OUT_W'(max_s);
      end else if (r < -max_s) begin
         rate_sel = RATE_OUT_W'(-max_s);
      end else begin
         rate_sel = RATE_OUT_W'(r);
      end
   end

   // control flags and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff      <= MOUNT_RESET;
         gain_ff       <= GAIN_RESET;
         deadband_ff   <= DEADBAND_RESET;
         max_rate_ff   <= MAX_RATE_RESET;
         timeout_ff    <= TIMEOUT_RESET;
         frame_open_ff <= 1'b0;
         have_frame_ff <= 1'b0;
         have_joint_ff <= 1'b0;
         ticks_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_MOUNT_OFFSET:  mount_ff    <= $signed(csr_data[MOUNT_W-1:0]);
               REG_LOOP_GAIN:     gain_ff     <= csr_data[GAIN_W-1:0];
               REG_DEADBAND:      deadband_ff <= csr_data[DEADBAND_W-1:0];
               REG_MAX_RATE:      max_rate_ff <= csr_data[MAX_RATE_W-1:0];
               REG_TIMEOUT_TICKS: timeout_ff  <= csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         if (cmd.capture && (req_opcode == OP_JOINT)) begin
            have_joint_ff <= 1'b1;
         end
         if (cmd.capture && (req_opcode == OP_TICK) && (ticks_ff != TICK_MAX)) begin
            ticks_ff <= ticks_ff + 1'b1;
         end
         if (cmd.pt_update) begin
            frame_open_ff <= !last_ff;
            if (last_ff) begin
               have_frame_ff <= 1'b1;
               ticks_ff      <= '0;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture && (req_opcode == OP_POINT)) begin
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         sqx_ff  <= sqx_full[SQ_W-1:0];
         sqy_ff  <= sqy_full[SQ_W-1:0];
         last_ff <= req_last_point;
      end
      if (cmd.capture && (req_opcode == OP_JOINT)) begin
         waist_ff <= req_joint_angle;
      end
      if (cmd.pt_update && take) begin
         best_d_ff <= pt_dist;
         best_x_ff <= px_ff;
         best_y_ff <= py_ff;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      if (cmd.bear_write) begin
         bearing_ff <= z_round[Z_SHIFT +: BEARING_W];
      end
      w_ff <= w_in;
      if (cmd.err_load) begin
         neg_ff <= err_raw < 0;
      end
      if (cmd.mul_load) begin
         prod_ff <= PROD_W'(ew) * PROD_W'($signed({1'b0, gain_ff}));
         dead_ff <= mag <= deadband_ff;
      end
      if (cmd.out_load) begin
         unique case (cmd.out_kind)
            OUT_ZERO: begin
               pub_ff  <= 1'b0;
               rate_ff <= '0;
               to_ff   <= 1'b0;
            end
            OUT_TIMEOUT: begin
               pub_ff  <= 1'b1;
               rate_ff <= '0;
               to_ff   <= 1'b1;
            end
            default: begin
               pub_ff  <= 1'b1;
               rate_ff <= rate_sel;
               to_ff   <= 1'b0;
            end
         endcase
      end
   end

endmodule

### rtl/nphc_checker.sv
// ----------------------------------------------------------------------------
// nphc_checker
// Port-level checks of the heading controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_point_heading_controller_assert.svh"

module nphc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [nphc_pkg::OPCODE_W-1:0]        req_opcode,
   input logic                                 req_last_point,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_publish,
   input logic [nphc_pkg::RATE_OUT_W-1:0]      rsp_angular_rate,
   input logic                                 rsp_timed_out
);
   import nphc_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // hold a stalled result word
   `NPHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_publish) && $stable(rsp_angular_rate) && $stable(rsp_timed_out), "result word changed while stalled")

   // only a tick may raise a result
   `NPHC_ASSERT_NEXT(a_no_spurious, req_fire && (req_opcode != OP_TICK) && !rsp_valid, !rsp_valid, "result appeared after a non-tick word")

   // a tick keeps the input stalled while its result is formed
   `NPHC_ASSERT_NEXT(a_tick_busy, req_fire && (req_opcode == OP_TICK), !req_ready, "input accepted during tick evaluation")

   // the last point of a frame starts the bearing update
   `NPHC_ASSERT_NOW(a_last_busy, req_fire && (req_opcode == OP_POINT) && req_last_point, ##2 !req_ready, "input accepted during bearing update")

endmodule

bind nearest_point_heading_controller nphc_checker u_nphc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_opcode       (req_ch.opcode),
   .req_last_point   (req_ch.last_point),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_publish      (rsp_ch.publish),
   .rsp_angular_rate (rsp_ch.angular_rate),
   .rsp_timed_out    (rsp_ch.timed_out)
);
